>>> hw/rtl/assert_macros.svh
// assertion macros shared by the rls echo canceller rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define RLS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define RLS_NEVER(lbl, cond, msg) \
    `RLS_ASSERT(lbl, !(cond), msg)

`endif

>>> hw/rtl/rls_pkg.sv
// shared constants, types and saturation helpers for the rls echo canceller
package rls_pkg;

    localparam int DEF_TAPS   = 32;
    localparam int SAMPLE_W   = 16;
    localparam int WORD_W     = 32;
    localparam int ACC_W      = 64;
    localparam int LAMBDA_W   = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 16;
    localparam int DIV_N_W    = 64;
    localparam int DIV_D_W    = 54;
    localparam int DIV_Q_W    = 32;

    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 16'd655;
    localparam logic signed [WORD_W-1:0] P_DIAG_INIT = 32'sd32768;

    // control that travels with one multiply-accumulate operand pair
    typedef struct packed {
        logic v;
        logic first;
        logic last;
    } mac_ctl_t;

    // divider request: magnitudes plus result sign
    typedef struct packed {
        logic               v;
        logic               neg;
        logic [DIV_N_W-1:0] n;
        logic [DIV_D_W-1:0] d;
    } div_req_t;

    typedef struct packed {
        logic                     v;
        logic signed [WORD_W-1:0] q;
    } div_res_t;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[WORD_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > 64'sd32767)
            return 16'sh7fff;
        if (v < -64'sd32768)
            return 16'sh8000;
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

>>> hw/rtl/rls_mac.sv
// registered multiplier followed by a run accumulator
`include "assert_macros.svh"

module rls_mac #(
    parameter int IDX_W = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rls_pkg::mac_ctl_t              in_ctl,
    input  logic [IDX_W-1:0]               in_idx,
    input  logic signed [rls_pkg::WORD_W-1:0] a,
    input  logic signed [rls_pkg::WORD_W-1:0] b,
    input  logic signed [rls_pkg::ACC_W-1:0]  init,
    output logic                           prod_v,
    output logic signed [rls_pkg::ACC_W-1:0]  prod,
    output logic [IDX_W-1:0]               prod_idx,
    output logic                           sum_v,
    output logic signed [rls_pkg::ACC_W-1:0]  sum,
    output logic [IDX_W-1:0]               sum_idx,
    output logic                           busy
);
    import rls_pkg::*;

    mac_ctl_t                  pctl_reg;
    logic signed [ACC_W-1:0]   prod_reg;
    logic [IDX_W-1:0]          pidx_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic                      sum_v_reg;
    logic [IDX_W-1:0]          sidx_reg;

    // product stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pctl_reg  <= '0;
            sum_v_reg <= 1'b0;
        end
        else
        begin
            pctl_reg  <= in_ctl;
            sum_v_reg <= pctl_reg.v && pctl_reg.last;
        end
    end

    // product and accumulator payload
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        pidx_reg <= in_idx;
        if (pctl_reg.v)
        begin
            acc_reg  <= acc_next;
            sidx_reg <= pidx_reg;
        end
    end

    // a run restarts from init on its first element
    assign acc_next = (pctl_reg.first ? init : acc_reg) + prod_reg;

    assign prod_v   = pctl_reg.v;
    assign prod     = prod_reg;
    assign prod_idx = pidx_reg;
    assign sum_v    = sum_v_reg;
    assign sum      = acc_reg;
    assign sum_idx  = sidx_reg;
    assign busy     = pctl_reg.v || sum_v_reg;

    `RLS_ASSERT(a_mac_run_end, (in_ctl.v && in_ctl.last) |-> ##2 sum_v, "run end lost in mac")

endmodule

>>> hw/rtl/rls_div.sv
// pipelined restoring divider with 32-bit signed saturated quotient
`include "assert_macros.svh"

module rls_div #(
    parameter int TAG_W = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rls_pkg::div_req_t  req,
    input  logic [TAG_W-1:0]   req_tag,
    output rls_pkg::div_res_t  res,
    output logic [TAG_W-1:0]   res_tag,
    output logic               busy
);
    import rls_pkg::*;

    localparam int STEPS = DIV_Q_W;
    localparam int CMP_W = DIV_D_W + DIV_Q_W;
    localparam int OBS_LAT = STEPS + 2;

    logic [STEPS:0]            v_reg;
    logic                      neg_reg [STEPS+1];
    logic                      ovf_reg [STEPS+1];
    logic [DIV_N_W-1:0]        rem_reg [STEPS+1];
    logic [DIV_Q_W-1:0]        q_reg   [STEPS+1];
    logic [DIV_D_W-1:0]        d_reg   [STEPS+1];
    logic [TAG_W-1:0]          tag_reg [STEPS+1];
    logic                      res_v_reg;
    logic signed [WORD_W-1:0]  res_q_reg;
    logic [TAG_W-1:0]          res_tag_reg;
    logic                      sat;
    logic [DIV_Q_W-1:0]        q_last;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            v_reg     <= {v_reg[STEPS-1:0], req.v};
            res_v_reg <= v_reg[STEPS];
        end
    end

    // entry stage: quotient of 2^32 or more saturates regardless of sign
    always_ff @(posedge clk)
    begin
        neg_reg[0] <= req.neg;
        ovf_reg[0] <= {{(DIV_D_W-32){1'b0}}, req.n[DIV_N_W-1:32]} >= req.d;
        rem_reg[0] <= req.n;
        q_reg[0]   <= '0;
        d_reg[0]   <= req.d;
        tag_reg[0] <= req_tag;
    end

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam int BIT = STEPS - 1 - k;
        logic [CMP_W-1:0] shifted;
        logic             take;

        assign shifted = CMP_W'(d_reg[k]) << BIT;
        assign take    = CMP_W'(rem_reg[k]) >= shifted;

        always_ff @(posedge clk)
        begin
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
            d_reg[k+1]   <= d_reg[k];
            tag_reg[k+1] <= tag_reg[k];
            rem_reg[k+1] <= take ? (rem_reg[k] - shifted[DIV_N_W-1:0]) : rem_reg[k];
            q_reg[k+1]   <= q_reg[k] | (DIV_Q_W'(take) << BIT);
        end
    end

    // sign and saturation
    assign q_last = q_reg[STEPS];
    assign sat    = ovf_reg[STEPS] || q_last[DIV_Q_W-1];

    always_ff @(posedge clk)
    begin
        res_tag_reg <= tag_reg[STEPS];
        if (neg_reg[STEPS])
            res_q_reg <= sat ? 32'sh80000000 : -$signed(q_last);
        else
            res_q_reg <= sat ? 32'sh7fffffff : $signed(q_last);
    end

    assign res.v   = res_v_reg;
    assign res.q   = res_q_reg;
    assign res_tag = res_tag_reg;
    assign busy    = (|v_reg) || res_v_reg;

    `RLS_ASSERT(a_div_latency, req.v |-> ##OBS_LAT res.v, "divider result missing")

endmodule

>>> hw/rtl/rls_adaptive_echo_canceller_core.sv
// top level of the rls adaptive echo canceller: sequencer, state memories, datapath
//
// Usage
//   s_axis carries one transaction per sample pair: ref_sample in tdata[15:0],
//   mic_sample in tdata[31:16]. m_axis returns one transaction per input with
//   the echo-cancelled out_sample in tdata[15:0].
//   cfg_we/cfg_wdata write lambda (Q0.16); write it only while the block is idle.
// Reset
//   rst_n clears control at once; afterwards a clearing pass over all TAPS*TAPS
//   entries loads the inverse-correlation memory diagonal and clears history
//   and coefficients. s_axis_tready stays low during that pass.
// Sequence
//   out_sample is registered once the estimate pass is done. The block then
//   adapts and takes no new input until s_axis_tready returns: most of that
//   time goes to three passes over the TAPS*TAPS inverse-correlation memory
//   through its single read port, and the gain and update divisions go
//   through a 34-stage divider pipeline.
// Stall
//   the result is held in an output register; if m_axis_tready stays low the
//   sequencer waits before adaptation until that register is free.
`include "assert_macros.svh"

module rls_adaptive_echo_canceller_core #(
    parameter int TAPS = rls_pkg::DEF_TAPS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rls_pkg::LAMBDA_W-1:0]    cfg_wdata,  // lambda
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rls_pkg::S_TDATA_W-1:0]   s_axis_tdata, // ref_sample, mic_sample
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rls_pkg::M_TDATA_W-1:0]   m_axis_tdata  // out_sample
);
    import rls_pkg::*;

    localparam int NP    = TAPS * TAPS;
    localparam int IDX_W = $clog2(TAPS);
    localparam int PA_W  = $clog2(NP);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS - 1);
    localparam logic [PA_W-1:0]  PA_STEP  = PA_W'(TAPS);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_EST  = 4'd2;
    localparam logic [3:0] S_OUT  = 4'd3;
    localparam logic [3:0] S_PTX  = 4'd4;
    localparam logic [3:0] S_XP   = 4'd5;
    localparam logic [3:0] S_DEN  = 4'd6;
    localparam logic [3:0] S_GAIN = 4'd7;
    localparam logic [3:0] S_UPD  = 4'd8;
    localparam logic [3:0] S_COEF = 4'd9;

    // sequencer state
    logic [3:0]        state_reg, state_next;
    logic              iss_reg, iss_next;
    logic [IDX_W-1:0]  icnt_reg, icnt_next;
    logic [IDX_W-1:0]  ocnt_reg, ocnt_next;
    logic [IDX_W-1:0]  ha_reg, ha_next;
    logic [PA_W-1:0]   pa_reg, pa_next;
    logic [IDX_W-1:0]  wp_reg, wp_next;
    logic [IDX_W-1:0]  newest_reg, newest_next;
    logic [LAMBDA_W-1:0] lam_reg;

    // payload registers
    logic signed [SAMPLE_W-1:0] mic_reg;
    logic signed [SAMPLE_W-1:0] e_reg;
    logic                       m_tvalid_reg;
    logic [M_TDATA_W-1:0]       m_tdata_reg;
    logic                       den_neg_reg;
    logic [DIV_D_W-1:0]         den_mag_reg;
    logic signed [WORD_W-1:0]   aux_reg;

    // memories
    logic [SAMPLE_W-1:0]      hist_mem [TAPS];
    logic signed [WORD_W-1:0] coef_mem [TAPS];
    logic signed [WORD_W-1:0] p_mem    [NP];
    logic signed [WORD_W-1:0] ptx_mem  [TAPS];
    logic signed [WORD_W-1:0] gain_mem [TAPS];
    logic signed [WORD_W-1:0] xp_mem   [TAPS];

    logic [SAMPLE_W-1:0]      hist_rd;
    logic signed [WORD_W-1:0] coef_rd, p_rd, ptx_rd, gain_rd, xp_rd;

    // read stage control
    mac_ctl_t          rd_ctl_reg, rd_ctl_next;
    logic [PA_W-1:0]   rd_idx_reg, rd_idx_next;

    // misc control
    logic last_in, last_out, dbl, rd_phase, issue, clr_wr, accept, inflight, out_load;
    logic [LAMBDA_W-1:0] lam_eff;

    // mac interface
    mac_ctl_t                 mac_in;
    logic signed [WORD_W-1:0] mac_a, mac_b;
    logic signed [ACC_W-1:0]  mac_init;
    logic                     mac_prod_v, mac_sum_v, mac_busy;
    logic signed [ACC_W-1:0]  mac_prod, mac_sum;
    logic [PA_W-1:0]          mac_prod_idx, mac_sum_idx;

    // divider interface
    div_req_t          div_req, gain_req, upd_req;
    div_res_t          div_res;
    logic [PA_W-1:0]   div_req_tag, div_tag;
    logic              div_busy;

    // datapath results
    logic signed [ACC_W-1:0]  est_q, err, sum_rnd, den_val, den_abs;
    logic signed [ACC_W-1:0]  upd_d, upd_abs, coef_upd, coef_sum;
    logic [WORD_W-1:0]        ptx_mag;
    logic signed [SAMPLE_W-1:0] hist_s;

    assign lam_eff  = (lam_reg == '0) ? LAMBDA_W'(1) : lam_reg;
    assign last_in  = icnt_reg == LAST_IDX;
    assign dbl      = (state_reg == S_CLR) || (state_reg == S_PTX) ||
                      (state_reg == S_XP) || (state_reg == S_UPD);
    assign last_out = !dbl || (ocnt_reg == LAST_IDX);
    assign rd_phase = (state_reg == S_EST) || (state_reg == S_PTX) ||
                      (state_reg == S_XP) || (state_reg == S_DEN) ||
                      (state_reg == S_GAIN) || (state_reg == S_UPD) ||
                      (state_reg == S_COEF);
    assign issue    = iss_reg && rd_phase;
    assign clr_wr   = iss_reg && (state_reg == S_CLR);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign inflight = rd_ctl_reg.v || mac_busy || div_busy;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_axis_tready);

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        iss_next    = iss_reg;
        icnt_next   = icnt_reg;
        ocnt_next   = ocnt_reg;
        ha_next     = ha_reg;
        pa_next     = pa_reg;
        wp_next     = wp_reg;
        newest_next = newest_reg;

        // loop counters and address walkers
        if (iss_reg && (rd_phase || state_reg == S_CLR))
        begin
            if (last_in)
            begin
                icnt_next = '0;
                ocnt_next = ocnt_reg + IDX_W'(1);
                ha_next   = newest_reg;
                if (last_out)
                    iss_next = 1'b0;
            end
            else
            begin
                icnt_next = icnt_reg + IDX_W'(1);
                ha_next   = (ha_reg == '0) ? LAST_IDX : ha_reg - IDX_W'(1);
            end
            if (state_reg == S_XP)
                pa_next = last_in ? PA_W'(ocnt_reg) + PA_W'(1) : pa_reg + PA_STEP;
            else
                pa_next = pa_reg + PA_W'(1);
        end

        case (state_reg)
            S_CLR:
            begin
                if (iss_reg && last_in && last_out)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next  = S_EST;
                    newest_next = wp_reg;
                    ha_next     = wp_reg;
                    wp_next     = (wp_reg == LAST_IDX) ? '0 : wp_reg + IDX_W'(1);
                end
            end
            S_EST:
            begin
                if (!iss_reg && !inflight)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_PTX;
            end
            S_PTX:
            begin
                if (!iss_reg && !inflight)
                    state_next = S_XP;
            end
            S_XP:
            begin
                if (!iss_reg && !inflight)
                    state_next = S_DEN;
            end
            S_DEN:
            begin
                if (!iss_reg && !inflight)
                    state_next = S_GAIN;
            end
            S_GAIN:
            begin
                if (!iss_reg && !inflight)
                    state_next = S_UPD;
            end
            S_UPD:
            begin
                if (!iss_reg && !inflight)
                    state_next = S_COEF;
            end
            S_COEF:
            begin
                if (!iss_reg && !inflight)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase

        // every new phase starts its loops from zero at the newest sample
        if (state_next != state_reg && state_next != S_IDLE && state_next != S_OUT)
        begin
            iss_next  = 1'b1;
            icnt_next = '0;
            ocnt_next = '0;
            pa_next   = '0;
            if (state_reg != S_IDLE)
                ha_next = newest_reg;
        end
    end

    // read stage control
    always_comb
    begin
        rd_ctl_next.v     = issue;
        rd_ctl_next.first = icnt_reg == '0;
        rd_ctl_next.last  = last_in;
        if (state_reg == S_UPD)
            rd_idx_next = pa_reg;
        else if (dbl)
            rd_idx_next = PA_W'(ocnt_reg);
        else
            rd_idx_next = PA_W'(icnt_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            iss_reg      <= 1'b1;
            icnt_reg     <= '0;
            ocnt_reg     <= '0;
            ha_reg       <= '0;
            pa_reg       <= '0;
            wp_reg       <= '0;
            newest_reg   <= '0;
            lam_reg      <= LAMBDA_RESET;
            rd_ctl_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            iss_reg    <= iss_next;
            icnt_reg   <= icnt_next;
            ocnt_reg   <= ocnt_next;
            ha_reg     <= ha_next;
            pa_reg     <= pa_next;
            wp_reg     <= wp_next;
            newest_reg <= newest_next;
            rd_ctl_reg <= rd_ctl_next;
            if (cfg_we)
                lam_reg <= cfg_wdata;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_axis_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // history memory
    always_ff @(posedge clk)
    begin
        if (clr_wr && ocnt_reg == '0)
            hist_mem[icnt_reg] <= '0;
        else if (accept)
            hist_mem[wp_reg] <= s_axis_tdata[SAMPLE_W-1:0];
        hist_rd <= hist_mem[ha_reg];
    end

    // coefficient memory, read-modify-write in the coefficient pass
    always_ff @(posedge clk)
    begin
        if (clr_wr && ocnt_reg == '0)
            coef_mem[icnt_reg] <= '0;
        else if (mac_prod_v && state_reg == S_COEF)
            coef_mem[mac_prod_idx[IDX_W-1:0]] <= sat32(coef_sum);
        coef_rd <= coef_mem[icnt_reg];
    end

    // inverse-correlation memory
    always_ff @(posedge clk)
    begin
        if (clr_wr)
            p_mem[pa_reg] <= (icnt_reg == ocnt_reg) ? P_DIAG_INIT : '0;
        else if (div_res.v && state_reg == S_UPD)
            p_mem[div_tag] <= div_res.q;
        p_rd <= p_mem[pa_reg];
    end

    // p_times_x memory
    always_ff @(posedge clk)
    begin
        if (mac_sum_v && state_reg == S_PTX)
            ptx_mem[mac_sum_idx[IDX_W-1:0]] <= sat32(sum_rnd);
        ptx_rd <= ptx_mem[icnt_reg];
    end

    // x'P row memory
    always_ff @(posedge clk)
    begin
        if (mac_sum_v && state_reg == S_XP)
            xp_mem[mac_sum_idx[IDX_W-1:0]] <= sat32(sum_rnd);
        xp_rd <= xp_mem[icnt_reg];
    end

    // gain memory
    always_ff @(posedge clk)
    begin
        if (div_res.v && state_reg == S_GAIN)
            gain_mem[div_tag[IDX_W-1:0]] <= div_res.q;
        gain_rd <= gain_mem[(state_reg == S_UPD) ? ocnt_reg : icnt_reg];
    end

    // operand selection for the shared multiplier
    assign hist_s = hist_rd;
    always_comb
    begin
        mac_in   = rd_ctl_reg;
        mac_a    = p_rd;
        mac_b    = WORD_W'(hist_s);
        mac_init = '0;
        case (state_reg)
            S_EST:
            begin
                mac_a = coef_rd;
            end
            S_DEN:
            begin
                mac_a    = ptx_rd;
                mac_init = $signed({33'd0, lam_eff, 15'd0});
            end
            S_GAIN:
            begin
                mac_in.v = 1'b0;
            end
            S_UPD:
            begin
                // per-entry products only, no run sums
                mac_in.last = 1'b0;
                mac_a = gain_rd;
                mac_b = xp_rd;
            end
            S_COEF:
            begin
                mac_in.last = 1'b0;
                mac_a = gain_rd;
                mac_b = WORD_W'(e_reg);
            end
            default:
            begin
                mac_a = p_rd;
            end
        endcase
    end

    rls_mac #(
        .IDX_W (PA_W)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ctl   (mac_in),
        .in_idx   (rd_idx_reg),
        .a        (mac_a),
        .b        (mac_b),
        .init     (mac_init),
        .prod_v   (mac_prod_v),
        .prod     (mac_prod),
        .prod_idx (mac_prod_idx),
        .sum_v    (mac_sum_v),
        .sum      (mac_sum),
        .sum_idx  (mac_sum_idx),
        .busy     (mac_busy)
    );

    // read index and memory word aligned with the product stage
    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        aux_reg    <= (state_reg == S_UPD) ? p_rd : coef_rd;
    end

    // run results: rounding and saturation
    assign est_q   = (mac_sum + 64'sd134217728) >>> 28;
    assign err     = ACC_W'(mic_reg) - est_q;
    assign sum_rnd = (mac_sum + 64'sd16384) >>> 15;
    assign den_val = (mac_sum == '0) ? 64'sd1 : mac_sum;
    assign den_abs = den_val[ACC_W-1] ? -den_val : den_val;

    always_ff @(posedge clk)
    begin
        if (accept)
            mic_reg <= s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
        if (mac_sum_v && state_reg == S_EST)
            e_reg <= sat16(err);
        if (mac_sum_v && state_reg == S_DEN)
        begin
            den_neg_reg <= den_val[ACC_W-1];
            den_mag_reg <= den_abs[DIV_D_W-1:0];
        end
        if (out_load)
            m_tdata_reg <= e_reg;
    end

    // coefficient update: coeff + round(gain * e / 8)
    assign coef_upd = (mac_prod + 64'sd4) >>> 3;
    assign coef_sum = ACC_W'(aux_reg) + coef_upd;

    // divider requests: gain from p_times_x, P entry from (P*2^16 - gain*xp)
    assign ptx_mag = ptx_rd[WORD_W-1] ? WORD_W'(-ptx_rd) : WORD_W'(ptx_rd);
    assign upd_d   = (ACC_W'(aux_reg) <<< 16) - mac_prod;
    assign upd_abs = upd_d[ACC_W-1] ? -upd_d : upd_d;

    always_comb
    begin
        gain_req.v   = rd_ctl_reg.v;
        gain_req.neg = ptx_rd[WORD_W-1] ^ den_neg_reg;
        gain_req.n   = {1'b0, ptx_mag, 31'd0};
        gain_req.d   = den_mag_reg;

        upd_req.v    = mac_prod_v;
        upd_req.neg  = upd_d[ACC_W-1];
        upd_req.n    = upd_abs;
        upd_req.d    = {{(DIV_D_W-LAMBDA_W){1'b0}}, lam_eff};

        if (state_reg == S_GAIN)
        begin
            div_req     = gain_req;
            div_req_tag = rd_idx_reg;
        end
        else
        begin
            div_req     = upd_req;
            div_req.v   = upd_req.v && (state_reg == S_UPD);
            div_req_tag = mac_prod_idx;
        end
    end

    rls_div #(
        .TAG_W (PA_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .req_tag (div_req_tag),
        .res     (div_res),
        .res_tag (div_tag),
        .busy    (div_busy)
    );

    `RLS_ASSERT(a_div_phase, div_res.v |-> (state_reg == S_GAIN || state_reg == S_UPD), "divider result outside its pass")
    `RLS_ASSERT(a_sum_phase, mac_sum_v |-> (state_reg == S_EST || state_reg == S_PTX || state_reg == S_XP || state_reg == S_DEN), "run sum outside a summing pass")
    `RLS_ASSERT(a_accept_start, accept |=> (state_reg == S_EST && iss_reg), "accepted transaction did not start estimate")
    `RLS_NEVER(a_out_clobber, out_load && m_tvalid_reg && !m_axis_tready, "output register overwritten")

endmodule

>>> verif/testbench.sv
// testbench for the rls adaptive echo canceller core: bit-exact scoreboard and stream drivers
`timescale 1ns / 100ps

module testbench;

    import rls_pkg::*;

    localparam int NTAPS       = DEF_TAPS;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int DRAIN_WAIT  = 3 * NTAPS * NTAPS + 4 * NTAPS + 200;

    // bit-exact model of the canceller: history, coefficients, inverse correlation
    class echo_scoreboard;
        logic [LAMBDA_W-1:0] lambda_q;
        shortint             hist[NTAPS];
        int                  wr_slot;
        int                  coef[NTAPS];
        int                  pinv[NTAPS][NTAPS];
        shortint             expected_out[$];
        int                  errors;
        int                  matched;

        function new();
            lambda_q = LAMBDA_RESET;
            wr_slot  = 0;
            errors   = 0;
            matched  = 0;
            for (int i = 0; i < NTAPS; i++)
            begin
                hist[i] = 0;
                coef[i] = 0;
                for (int j = 0; j < NTAPS; j++)
                    pinv[i][j] = (i == j) ? 32768 : 0;
            end
        endfunction

        function longint round_down(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        function int clamp32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return int'(v);
        endfunction

        function shortint clamp16(longint v);
            if (v > 64'sd32767)
                return 16'sh7fff;
            if (v < -64'sd32768)
                return 16'sh8000;
            return shortint'(v);
        endfunction

        function void set_lambda(logic [LAMBDA_W-1:0] v);
            lambda_q = v;
        endfunction

        // one accepted sample pair: predict the output, then adapt
        function void note_input(shortint ref_s, shortint mic_s);
            longint  x[NTAPS];
            int      ptx[NTAPS];
            int      gn[NTAPS];
            int      xp[NTAPS];
            longint  acc;
            longint  den;
            longint  lam;
            longint  diff;
            shortint e;

            hist[wr_slot] = ref_s;
            wr_slot = (wr_slot + 1) % NTAPS;
            for (int i = 0; i < NTAPS; i++)
                x[i] = hist[(wr_slot + NTAPS - 1 - i) % NTAPS];

            // echo estimate and saturated error
            acc = 0;
            for (int i = 0; i < NTAPS; i++)
                acc += longint'(coef[i]) * x[i];
            e = clamp16(longint'(mic_s) - round_down(acc, 28));
            expected_out.push_back(e);

            // zero lambda acts as one
            lam = (lambda_q == 0) ? 64'sd1 : longint'({48'd0, lambda_q});

            for (int i = 0; i < NTAPS; i++)
            begin
                acc = 0;
                for (int j = 0; j < NTAPS; j++)
                    acc += longint'(pinv[i][j]) * x[j];
                ptx[i] = clamp32(round_down(acc, 15));
            end

            // zero denominator is replaced by one
            den = lam * 32768;
            for (int i = 0; i < NTAPS; i++)
                den += x[i] * longint'(ptx[i]);
            if (den == 0)
                den = 1;

            for (int i = 0; i < NTAPS; i++)
                gn[i] = clamp32((longint'(ptx[i]) * (64'sd1 <<< 31)) / den);

            for (int j = 0; j < NTAPS; j++)
            begin
                acc = 0;
                for (int i = 0; i < NTAPS; i++)
                    acc += x[i] * longint'(pinv[i][j]);
                xp[j] = clamp32(round_down(acc, 15));
            end

            for (int i = 0; i < NTAPS; i++)
                for (int j = 0; j < NTAPS; j++)
                begin
                    diff = longint'(pinv[i][j]) * 65536 - longint'(gn[i]) * longint'(xp[j]);
                    pinv[i][j] = clamp32(diff / lam);
                end

            // adaptation uses the saturated error
            for (int i = 0; i < NTAPS; i++)
                coef[i] = clamp32(longint'(coef[i]) + round_down(longint'(gn[i]) * e, 3));
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] actual);
            shortint exp_s;
            if (expected_out.size() == 0)
            begin
                $display("%0t: unexpected output transaction, actual %0d", $time,
                         $signed(actual));
                errors++;
                return;
            end
            exp_s = expected_out.pop_front();
            if (exp_s !== $signed(actual))
            begin
                $display("%0t: out_sample mismatch, expected %0d actual %0d", $time,
                         exp_s, $signed(actual));
                errors++;
            end
            else
                matched++;
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [LAMBDA_W-1:0]    cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata;   // ref_sample, mic_sample
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [M_TDATA_W-1:0]   m_axis_tdata;   // out_sample

    echo_scoreboard sb;
    int             cycles;
    int             rx_mode;
    int             lambda_writes;

    rls_adaptive_echo_canceller_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver stall pattern: modes of always ready, light and heavy stalling
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            rx_mode <= $urandom_range(0, 2);
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // output transaction monitor
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    task automatic send_sample(shortint ref_s, shortint mic_s, int gap);
        s_axis_tdata  <= {mic_s, ref_s};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(ref_s, mic_s);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // lambda is written only when the block is idle
    task automatic write_lambda(logic [LAMBDA_W-1:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_out.size() != 0)
            @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_lambda(v);
        lambda_writes++;
    endtask

    function automatic shortint pick_sample(int kind);
        case (kind)
            0: return shortint'($urandom_range(0, 65535));
            1: return shortint'($urandom_range(0, 511)) - 16'sd256;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return shortint'($urandom_range(0, 8191)) - 16'sd4096;
        endcase
    endfunction

    // random samples sent in bursts separated by random gaps
    task automatic random_samples(int count);
        int burst;
        int gap;
        int kind;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (burst == 0)
                burst = $urandom_range(1, 8);
            burst--;
            gap = (burst == 0) ? $urandom_range(1, 40) : 0;
            kind = $urandom_range(0, 9);
            kind = (kind < 6) ? 0 : kind - 6;
            send_sample(pick_sample(kind), pick_sample($urandom_range(0, 3)), gap);
        end
    endtask

    initial
    begin
        sb            = new();
        cycles        = 0;
        rx_mode       = 0;
        lambda_writes = 0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes of both samples under the reset lambda
        send_sample(16'sh7fff, 16'sh7fff, 0);
        send_sample(16'sh8000, 16'sh8000, 0);
        send_sample(16'sh7fff, 16'sh8000, 3);
        send_sample(16'sh8000, 16'sh7fff, 0);
        send_sample(16'sh0000, 16'sh0000, 1);
        send_sample(16'sh0001, 16'shffff, 0);
        send_sample(16'shffff, 16'sh0001, 0);
        send_sample(16'sh5555, 16'shaaaa, 2);
        send_sample(16'shaaaa, 16'sh5555, 0);
        for (int n = 0; n < 6; n++)
            send_sample(16'sh8000, 16'sh7fff, n % 2);

        // zero lambda behaves as one, then the range extremes
        write_lambda(16'd0);
        send_sample(16'sh7fff, 16'sh0000, 0);
        send_sample(16'sh0000, 16'sh8000, 0);
        random_samples(15);
        write_lambda(16'd1);
        random_samples(20);
        write_lambda(16'hffff);
        random_samples(60);
        write_lambda(16'($urandom_range(1, 65535)));
        random_samples(40);
        write_lambda(16'($urandom_range(100, 4000)));
        random_samples(40);
        write_lambda(16'd655);
        random_samples(90);
        s_axis_tvalid <= 1'b0;

        // drain: all results in, then let adaptation finish
        while (sb.expected_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d checked outputs over %0d lambda settings (0, 1, 65535 included)",
                 sb.matched, lambda_writes + 1);
        $display("random sender bursts and receiver stalls, %0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.expected_out.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
